### sv/dfurq_pkg.sv
// Shared types and constants for the DFU request state machine.
package dfurq_pkg;

	typedef enum logic [3:0] {
		ST_IDLE     = 4'd2,
		ST_DN_SYNC  = 4'd3,
		ST_DN_IDLE  = 4'd5,
		ST_MAN_SYNC = 4'd6,
		ST_UP_IDLE  = 4'd9
	} dfu_state_t;

	typedef enum logic [2:0] {
		R_NONE    = 3'd0,
		R_STATUS  = 3'd1,
		R_STATE   = 3'd2,
		R_UPLOAD  = 3'd3,
		R_ZLP     = 3'd4,
		R_ARM_OUT = 3'd5,
		R_STALL   = 3'd6
	} resp_t;

	localparam logic [7:0] OP_DETACH    = 8'd0;
	localparam logic [7:0] OP_DNLOAD    = 8'd1;
	localparam logic [7:0] OP_UPLOAD    = 8'd2;
	localparam logic [7:0] OP_GETSTATUS = 8'd3;
	localparam logic [7:0] OP_CLRSTATUS = 8'd4;
	localparam logic [7:0] OP_GETSTATE  = 8'd5;
	localparam logic [7:0] OP_ABORT     = 8'd6;

	localparam logic [7:0] CFG_UPLOAD_BLOCK_SIZE  = 8'd0;
	localparam logic [7:0] CFG_LAST_BLOCK_INDEX   = 8'd1;
	localparam logic [7:0] CFG_WRITE_POLL_TIMEOUT = 8'd2;

	localparam logic [2:0] POLLS_PER_STAGE = 3'd5;

	localparam logic [12:0] UPLOAD_BLOCK_SIZE_RST  = 13'd512;
	localparam logic [15:0] LAST_BLOCK_INDEX_RST   = 16'd127;
	localparam logic [23:0] WRITE_POLL_TIMEOUT_RST = 24'd10;
	localparam logic [15:0] DN_STRIDE_RST          = 16'd512;

	typedef struct packed {
		logic [12:0] upload_block_size;
		logic [15:0] last_block_index;
		logic [23:0] write_poll_timeout;
	} cfg_t;

	typedef struct packed {
		dfu_state_t  state;
		logic [2:0]  poll_count;
		logic [15:0] block_index;
		logic [15:0] data_length;
		logic [15:0] dn_stride;
		logic [23:0] poll_timeout;
		logic        manifest_flag;
	} ctx_t;

	localparam ctx_t CTX_RST = '{
		state:         ST_IDLE,
		poll_count:    3'd0,
		block_index:   16'd0,
		data_length:   16'd0,
		dn_stride:     DN_STRIDE_RST,
		poll_timeout:  24'd0,
		manifest_flag: 1'b0
	};

	typedef struct packed {
		logic        dir_in;
		logic [7:0]  opcode;
		logic [15:0] w_value;
		logic [15:0] w_length;
	} req_t;

	typedef struct packed {
		resp_t       response;
		logic [3:0]  dfu_state_out;
		logic [23:0] poll_timeout_out;
		logic [15:0] xfer_len;
		logic        flash_write;
		logic        flash_read;
		logic [31:0] flash_addr;
		logic [15:0] flash_len;
		logic        reset_request;
		logic        manifest_done;
	} res_t;

endpackage

### sv/dfurq_state.sv
// Configuration registers and DFU context registers.
module dfurq_state import dfurq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_idx,
	input  logic [23:0] cfg_wdata,
	input  logic       upd,
	input  ctx_t       ctx_nxt,
	output cfg_t       cfg,
	output ctx_t       ctx
);

	cfg_t cfg_q;
	ctx_t ctx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.upload_block_size  <= UPLOAD_BLOCK_SIZE_RST;
			cfg_q.last_block_index   <= LAST_BLOCK_INDEX_RST;
			cfg_q.write_poll_timeout <= WRITE_POLL_TIMEOUT_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				CFG_UPLOAD_BLOCK_SIZE:  cfg_q.upload_block_size  <= cfg_wdata[12:0];
				CFG_LAST_BLOCK_INDEX:   cfg_q.last_block_index   <= cfg_wdata[15:0];
				CFG_WRITE_POLL_TIMEOUT: cfg_q.write_poll_timeout <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q <= CTX_RST;
		end else if (upd) begin
			ctx_q <= ctx_nxt;
		end
	end

	assign cfg = cfg_q;
	assign ctx = ctx_q;

endmodule

### sv/dfurq_step.sv
// Next-state and response logic for one DFU class request.
module dfurq_step import dfurq_pkg::*; (
	input  req_t req,
	input  ctx_t ctx,
	input  cfg_t cfg,
	output ctx_t ctx_nxt,
	output res_t res
);

	dfu_state_t  st;
	logic [2:0]  pc;
	logic [15:0] bi;
	logic [15:0] dl;
	logic [15:0] bs;
	logic [23:0] pt;
	logic        mf;
	resp_t       resp;
	logic [15:0] xlen;
	logic        fw;
	logic        fr;
	logic [15:0] flen;
	logic        rst;
	logic [15:0] mul_a;
	logic [15:0] mul_b;
	logic [31:0] prod;

	always_comb begin
		st   = ctx.state;
		pc   = ctx.poll_count;
		bi   = ctx.block_index;
		dl   = ctx.data_length;
		bs   = ctx.dn_stride;
		pt   = ctx.poll_timeout;
		mf   = ctx.manifest_flag;
		resp = R_NONE;
		xlen = 16'd0;
		fw   = 1'b0;
		fr   = 1'b0;
		flen = 16'd0;
		rst  = 1'b0;
		if (req.dir_in) begin
			unique case (req.opcode)
				OP_GETSTATUS: begin
					if (st == ST_DN_SYNC) begin
						pt = cfg.write_poll_timeout;
						pc = pc + 3'd1;
						if (pc == POLLS_PER_STAGE) begin
							pc   = 3'd0;
							st   = ST_DN_IDLE;
							fw   = 1'b1;
							flen = dl;
						end
					end
					if (st == ST_DN_IDLE) begin
						pc = pc + 3'd1;
						if (pc == POLLS_PER_STAGE) begin
							pc = 3'd0;
							st = ST_MAN_SYNC;
						end
					end
					if (st == ST_MAN_SYNC) begin
						pc = pc + 3'd1;
						if (pc == POLLS_PER_STAGE) begin
							pc = 3'd0;
							st = ST_IDLE;
							mf = 1'b1;
						end
					end
					resp = R_STATUS;
				end
				OP_GETSTATE: resp = R_STATE;
				OP_UPLOAD: begin
					if (st == ST_IDLE || st == ST_UP_IDLE) begin
						if (req.w_length == 16'd0) begin
							st = ST_IDLE;
						end else if (req.w_value > cfg.last_block_index) begin
							st   = ST_IDLE;
							resp = R_ZLP;
						end else begin
							st   = ST_UP_IDLE;
							fr   = 1'b1;
							flen = req.w_length;
							xlen = req.w_length;
							resp = R_UPLOAD;
						end
					end
				end
				default: resp = R_STALL;
			endcase
		end else begin
			unique case (req.opcode)
				OP_DETACH, OP_ABORT: begin
					if (st == ST_IDLE || st == ST_DN_SYNC || st == ST_DN_IDLE ||
					    st == ST_MAN_SYNC || st == ST_UP_IDLE) begin
						st  = ST_IDLE;
						bi  = 16'd0;
						dl  = 16'd0;
						rst = (req.opcode == OP_DETACH);
					end
					resp = R_ZLP;
				end
				OP_DNLOAD: begin
					if (st == ST_IDLE || st == ST_DN_IDLE) begin
						if (req.w_length != 16'd0) begin
							bi = req.w_value;
							dl = req.w_length;
							if (st == ST_IDLE) begin
								bs = req.w_length;
							end
							st   = ST_DN_SYNC;
							xlen = req.w_length;
							resp = R_ARM_OUT;
						end else begin
							pc   = 3'd0;
							mf   = 1'b0;
							st   = ST_MAN_SYNC;
							resp = R_ZLP;
						end
					end else begin
						resp = R_STALL;
					end
				end
				OP_CLRSTATUS: begin
					st   = ST_IDLE;
					resp = R_ZLP;
				end
				default: resp = R_STALL;
			endcase
		end
	end

	// one shared multiplier: block address for either a flash write or a read
	assign mul_a = fw ? ctx.block_index : req.w_value;
	assign mul_b = fw ? ctx.dn_stride : {3'b000, cfg.upload_block_size};
	assign prod  = {16'd0, mul_a} * {16'd0, mul_b};

	always_comb begin
		ctx_nxt.state         = st;
		ctx_nxt.poll_count    = pc;
		ctx_nxt.block_index   = bi;
		ctx_nxt.data_length   = dl;
		ctx_nxt.dn_stride     = bs;
		ctx_nxt.poll_timeout  = pt;
		ctx_nxt.manifest_flag = mf;

		res.response         = resp;
		res.dfu_state_out    = st;
		res.poll_timeout_out = pt;
		res.xfer_len         = xlen;
		res.flash_write      = fw;
		res.flash_read       = fr;
		res.flash_addr       = (fw || fr) ? prod : 32'd0;
		res.flash_len        = flen;
		res.reset_request    = rst;
		res.manifest_done    = mf;
	end

endmodule

### sv/dfu_request_state_machine.sv
// Top level: request input register, step logic and result output register.
// A word accepted is held in the request input register, stepped combinationally, and
//   registered in the result output register as the state registers update.
// Throughput: one request word per cycle unless m_axis_tready stalls the output; the
//   step is a single combinational pass with one 16x16 multiply for the flash address.
// Reset (arst_n low): state dfuIDLE, counters and flags cleared, stride 512,
//   registers at their defaults, both stages empty. No clearing pass.
module dfu_request_state_machine import dfurq_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // w_value, w_length
	input  logic [8:0]  s_axis_tuser,   // dir_in, opcode
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// dfu_state_out, poll_timeout_out, xfer_len, flash_write, flash_read,
	// flash_addr, flash_len, reset_request, manifest_done
	output logic [95:0] m_axis_tdata,
	output logic [2:0]  m_axis_tuser,   // response
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	req_t req_s1;
	logic s1_valid_q;
	res_t out_q;
	logic out_valid_q;
	logic adv;
	cfg_t cfg;
	ctx_t ctx;
	ctx_t ctx_nxt;
	res_t res;

	assign adv           = s1_valid_q && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !s1_valid_q || adv;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			req_s1.dir_in   <= s_axis_tuser[0];
			req_s1.opcode   <= s_axis_tuser[8:1];
			req_s1.w_value  <= s_axis_tdata[15:0];
			req_s1.w_length <= s_axis_tdata[31:16];
		end
	end

	dfurq_state u_state (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.upd       (adv),
		.ctx_nxt   (ctx_nxt),
		.cfg       (cfg),
		.ctx       (ctx)
	);

	dfurq_step u_step (
		.req     (req_s1),
		.ctx     (ctx),
		.cfg     (cfg),
		.ctx_nxt (ctx_nxt),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_q.response;
	assign m_axis_tdata  = {out_q.manifest_done, out_q.reset_request, out_q.flash_len,
	                        out_q.flash_addr, out_q.flash_read, out_q.flash_write,
	                        out_q.xfer_len, out_q.poll_timeout_out, out_q.dfu_state_out};

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> s1_valid_q)
		else $error("input stalled with empty stage");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> m_axis_tvalid)
		else $error("advanced word missing at output");

	a_ctx_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(ctx))
		else $error("context changed without a step");

	a_one_flash_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !(out_q.flash_write && out_q.flash_read))
		else $error("flash write and read together");

	a_addr_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !out_q.flash_write && !out_q.flash_read) |->
		(out_q.flash_addr == 32'd0 && out_q.flash_len == 16'd0))
		else $error("flash address or length without command");

endmodule
